/* design/zobrist_move_key_diff_defines.svh */
// assertion macros for the checker file
`ifndef ZOBRIST_MOVE_KEY_DIFF_DEFINES_SVH
`define ZOBRIST_MOVE_KEY_DIFF_DEFINES_SVH

// immediate implication, checked at the same edge
`define ZMKD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked at the next edge
`define ZMKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/zmkd_pkg.sv */
// shared constants, types and address helpers for the zobrist key diff block
package zmkd_pkg;

  localparam int PIECE_KINDS   = 6;
  localparam int BOARD_SQUARES = 64;
  localparam int SQ_W          = 6;
  localparam int EP_FILES      = 8;
  localparam int EP_BASE       = 2 * PIECE_KINDS * BOARD_SQUARES;
  localparam int SIDE_BASE     = EP_BASE + EP_FILES;
  localparam int CASTLE_BASE   = SIDE_BASE + 2;
  localparam int KEY_SLOTS     = CASTLE_BASE + 4;
  localparam int ADDR_W        = $clog2(KEY_SLOTS);
  localparam int KEY_W         = 64;
  localparam int NUM_READS     = 14;
  localparam int READ_IDX_W    = $clog2(NUM_READS);
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 2;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_NULL = 2'd2;

  localparam logic [2:0] MK_QUIET   = 3'd0;
  localparam logic [2:0] MK_DPUSH   = 3'd1;
  localparam logic [2:0] MK_CAPTURE = 3'd2;
  localparam logic [2:0] MK_EP      = 3'd3;
  localparam logic [2:0] MK_KCASTLE = 3'd4;
  localparam logic [2:0] MK_QCASTLE = 3'd5;

  localparam logic [2:0] KIND_PAWN    = 3'd0;
  localparam logic [2:0] KIND_ROOK    = 3'd3;
  localparam logic [2:0] NO_PROMOTION = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOK_WK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOK_WQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOK_BK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOK_BQ = 2'd3;

  localparam logic [SQ_W-1:0] ROOK_WK_RST = 6'd7;
  localparam logic [SQ_W-1:0] ROOK_WQ_RST = 6'd0;
  localparam logic [SQ_W-1:0] ROOK_BK_RST = 6'd63;
  localparam logic [SQ_W-1:0] ROOK_BQ_RST = 6'd56;

  // read slots of one diff
  localparam int RS_FROM    = 0;
  localparam int RS_TO      = 1;
  localparam int RS_OLD_EP  = 2;
  localparam int RS_NEW_EP  = 3;
  localparam int RS_CASTLE  = 4;
  localparam int RS_EXTRA_A = 8;
  localparam int RS_EXTRA_B = 9;
  localparam int RS_PROMO_P = 10;
  localparam int RS_PROMO_N = 11;
  localparam int RS_SIDE_W  = 12;
  localparam int RS_SIDE_B  = 13;

  typedef struct packed {
    logic [1:0]        op;
    logic [9:0]        key_index;
    logic [KEY_W-1:0]  key_value;
    logic              side;
    logic [2:0]        piece;
    logic [SQ_W-1:0]   from_square;
    logic [SQ_W-1:0]   to_square;
    logic [2:0]        taken_piece;
    logic [2:0]        move_kind;
    logic [2:0]        promote_to;
    logic [3:0]        castle_change;
    logic signed [3:0] old_ep_file;
  } in_item_t;

  typedef struct packed {
    logic                             wr_en;
    logic [ADDR_W-1:0]                wr_addr;
    logic [KEY_W-1:0]                 wr_data;
    logic [NUM_READS-1:0]             rd_mask;
    logic [NUM_READS-1:0][ADDR_W-1:0] rd_addr;
  } desc_t;

  function automatic logic [ADDR_W-1:0] piece_addr(input logic colour,
                                                   input logic [2:0] kind,
                                                   input logic [SQ_W-1:0] sq);
    return ADDR_W'((int'(colour) * PIECE_KINDS + int'(kind)) * BOARD_SQUARES
                   + int'(sq));
  endfunction

  function automatic logic kind_ok(input logic [2:0] kind);
    return int'(kind) < PIECE_KINDS;
  endfunction

endpackage

/* design/zmkd_ram.sv */
// generic simple dual port ram with registered read
module zmkd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/zmkd_front.sv */
// front end: castling rook registers and decode of an item into key reads
module zmkd_front
  import zmkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SQ_W-1:0]      cfg_wdata,
  input  in_item_t             item,
  output desc_t                desc
);

  logic [SQ_W-1:0] rook_wk_r, rook_wq_r, rook_bk_r, rook_bq_r;
  logic [SQ_W-1:0] home_k, home_q;
  logic            us, them, is_move, is_diff;
  logic [SQ_W-1:0] from_sq, to_sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rook_wk_r <= ROOK_WK_RST;
      rook_wq_r <= ROOK_WQ_RST;
      rook_bk_r <= ROOK_BK_RST;
      rook_bq_r <= ROOK_BQ_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROOK_WK: rook_wk_r <= cfg_wdata;
        CFG_ROOK_WQ: rook_wq_r <= cfg_wdata;
        CFG_ROOK_BK: rook_bk_r <= cfg_wdata;
        CFG_ROOK_BQ: rook_bq_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign us      = item.side;
  assign them    = ~item.side;
  assign from_sq = item.from_square;
  assign to_sq   = item.to_square;
  assign is_move = (item.op == OP_MOVE);
  assign is_diff = is_move || (item.op == OP_NULL);
  assign home_k  = us ? rook_bk_r : rook_wk_r;
  assign home_q  = us ? rook_bq_r : rook_wq_r;

  always_comb begin
    desc         = '0;
    desc.wr_en   = (item.op == OP_LOAD) && (int'(item.key_index) < KEY_SLOTS);
    desc.wr_addr = item.key_index[ADDR_W-1:0];
    desc.wr_data = item.key_value;

    desc.rd_mask[RS_FROM] = is_move && kind_ok(item.piece);
    desc.rd_addr[RS_FROM] = piece_addr(us, item.piece, from_sq);
    desc.rd_mask[RS_TO]   = is_move && kind_ok(item.piece);
    desc.rd_addr[RS_TO]   = piece_addr(us, item.piece, to_sq);

    desc.rd_mask[RS_OLD_EP] = is_diff && !item.old_ep_file[3];
    desc.rd_addr[RS_OLD_EP] = ADDR_W'(EP_BASE + int'(item.old_ep_file[2:0]));
    desc.rd_mask[RS_NEW_EP] = is_move && (item.move_kind == MK_DPUSH);
    desc.rd_addr[RS_NEW_EP] = ADDR_W'(EP_BASE + int'(from_sq[2:0]));

    for (int i = 0; i < 4; i++) begin
      desc.rd_mask[RS_CASTLE+i] = is_move && item.castle_change[i];
      desc.rd_addr[RS_CASTLE+i] = ADDR_W'(CASTLE_BASE + i);
    end

    case (item.move_kind)
      MK_EP: begin
        desc.rd_mask[RS_EXTRA_A] = is_move;
        desc.rd_addr[RS_EXTRA_A] = piece_addr(them, KIND_PAWN, {from_sq[5:3], to_sq[2:0]});
      end
      MK_CAPTURE: begin
        desc.rd_mask[RS_EXTRA_A] = is_move && kind_ok(item.taken_piece);
        desc.rd_addr[RS_EXTRA_A] = piece_addr(them, item.taken_piece, to_sq);
      end
      MK_KCASTLE: begin
        desc.rd_mask[RS_EXTRA_A] = is_move && kind_ok(KIND_ROOK);
        desc.rd_addr[RS_EXTRA_A] = piece_addr(us, KIND_ROOK, home_k);
        desc.rd_mask[RS_EXTRA_B] = is_move && kind_ok(KIND_ROOK);
        desc.rd_addr[RS_EXTRA_B] = piece_addr(us, KIND_ROOK, from_sq + SQ_W'(1));
      end
      MK_QCASTLE: begin
        desc.rd_mask[RS_EXTRA_A] = is_move && kind_ok(KIND_ROOK);
        desc.rd_addr[RS_EXTRA_A] = piece_addr(us, KIND_ROOK, home_q);
        desc.rd_mask[RS_EXTRA_B] = is_move && kind_ok(KIND_ROOK);
        desc.rd_addr[RS_EXTRA_B] = piece_addr(us, KIND_ROOK, from_sq - SQ_W'(1));
      end
      default: ;
    endcase

    desc.rd_mask[RS_PROMO_P] = is_move && (item.promote_to < NO_PROMOTION);
    desc.rd_addr[RS_PROMO_P] = piece_addr(us, KIND_PAWN, to_sq);
    desc.rd_mask[RS_PROMO_N] = is_move && (item.promote_to < NO_PROMOTION)
                               && kind_ok(item.promote_to);
    desc.rd_addr[RS_PROMO_N] = piece_addr(us, item.promote_to, to_sq);

    desc.rd_mask[RS_SIDE_W] = is_diff;
    desc.rd_addr[RS_SIDE_W] = ADDR_W'(SIDE_BASE);
    desc.rd_mask[RS_SIDE_B] = is_diff;
    desc.rd_addr[RS_SIDE_B] = ADDR_W'(SIDE_BASE + 1);
  end

endmodule

/* design/zmkd_queue.sv */
// small fifo of decoded descriptors between front and back
module zmkd_queue
  import zmkd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output desc_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + PTR_W'(1);
  endfunction

  assign full      = (int'(count_r) == QUEUE_DEPTH);
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

/* design/zmkd_back.sv */
// back end: walks the key reads of one descriptor and xors the keys
module zmkd_back
  import zmkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  desc_t             q_data,
  output logic              q_pop,
  output logic              ram_wr_en,
  output logic [ADDR_W-1:0] ram_wr_addr,
  output logic [KEY_W-1:0]  ram_wr_data,
  output logic              ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr,
  input  logic [KEY_W-1:0]  ram_rd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KEY_W-1:0]  out_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  logic [NUM_READS-1:0]             mask_r, mask_nxt;
  logic [NUM_READS-1:0][ADDR_W-1:0] addr_r, addr_nxt;
  logic                             pend_r, pend_nxt;
  logic [KEY_W-1:0]                 acc_r, acc_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]                 out_data_r, out_data_nxt;
  logic [READ_IDX_W-1:0]            sel_idx;

  // lowest pending read
  always_comb begin
    sel_idx = '0;
    for (int i = NUM_READS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel_idx = READ_IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    addr_nxt      = addr_r;
    pend_nxt      = 1'b0;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = q_data.wr_addr;
    ram_wr_data   = q_data.wr_data;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = addr_r[sel_idx];
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          ram_wr_en = q_data.wr_en;
          mask_nxt  = q_data.rd_mask;
          addr_nxt  = q_data.rd_addr;
          acc_nxt   = '0;
          state_nxt = (q_data.rd_mask == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        if (pend_r) begin
          acc_nxt = acc_r ^ ram_rd_data;
        end
        if (mask_r != '0) begin
          ram_rd_en = 1'b1;
          pend_nxt  = 1'b1;
          mask_nxt  = mask_r & ~(NUM_READS'(1) << sel_idx);
        end else if (!pend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      mask_r      <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/zobrist_move_key_diff.sv */
// Zobrist move key difference unit. Software loads the 782 random 64-bit keys
// (piece-square, en-passant file, side to move, castling) with load
// transactions; a move or null-move transaction returns the XOR of every key
// that move touches, and a load returns zero. The front end decodes each
// transaction into a list of key reads and parks it in a two-entry queue, so
// new transactions are taken while the queue has room, also while the back end
// works and while a result waits to be taken. The back end has one read port
// into the key table and reads one key per cycle. Keys read before they were
// ever loaded are undefined.
module zobrist_move_key_diff
  import zmkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [9:0]           in_key_index,
  input  logic [KEY_W-1:0]     in_key_value,
  input  logic                 in_side,
  input  logic [2:0]           in_piece,
  input  logic [SQ_W-1:0]      in_from_square,
  input  logic [SQ_W-1:0]      in_to_square,
  input  logic [2:0]           in_taken_piece,
  input  logic [2:0]           in_move_kind,
  input  logic [2:0]           in_promote_to,
  input  logic [3:0]           in_castle_change,
  input  logic signed [3:0]    in_old_ep_file,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KEY_W-1:0]     out_hash_delta,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SQ_W-1:0]      cfg_wdata
);

  in_item_t          item;
  desc_t             push_desc, pop_desc;
  logic              q_full, q_not_empty, q_pop;
  logic              ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
  logic [KEY_W-1:0]  ram_wr_data, ram_rd_data;

  assign item.op            = in_op;
  assign item.key_index     = in_key_index;
  assign item.key_value     = in_key_value;
  assign item.side          = in_side;
  assign item.piece         = in_piece;
  assign item.from_square   = in_from_square;
  assign item.to_square     = in_to_square;
  assign item.taken_piece   = in_taken_piece;
  assign item.move_kind     = in_move_kind;
  assign item.promote_to    = in_promote_to;
  assign item.castle_change = in_castle_change;
  assign item.old_ep_file   = in_old_ep_file;

  assign in_ready = !q_full;

  zmkd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .desc      (push_desc)
  );

  zmkd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_data (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_desc)
  );

  zmkd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_not_empty),
    .q_data      (pop_desc),
    .q_pop       (q_pop),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_hash_delta)
  );

  zmkd_ram #(
    .WIDTH (KEY_W),
    .DEPTH (KEY_SLOTS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

/* design/zmkd_checker.sv */
// port level checks for the zobrist key diff block, bound to the top level
`include "zobrist_move_key_diff_defines.svh"

module zmkd_checker
  import zmkd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [KEY_W-1:0] out_hash_delta
);

  logic [3:0] open_r;

  // transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_r + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
    end
  end

  `ZMKD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ZMKD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_hash_delta), "result changed while stalled")
  `ZMKD_ASSERT_SAME(a_no_invent, out_valid, open_r != 4'd0, "result without a pending transaction")
  `ZMKD_ASSERT_SAME(a_reset_quiet, $past(!rst_n), !out_valid, "result valid right after reset")

endmodule

bind zobrist_move_key_diff zmkd_checker u_zmkd_checker (.*);
